// File: hw/rtl/packet_sequence_gap_checker_defines.svh
// Assertion macros used by the checker file of the sequence gap checker.
`ifndef PACKET_SEQUENCE_GAP_CHECKER_DEFINES_SVH
`define PACKET_SEQUENCE_GAP_CHECKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSGC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSGC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Like the above, but also checked while reset is high.
`define PSGC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/psgc_pkg.sv
// Types and constants of the packet sequence gap checker.
package psgc_pkg;

   localparam int MAX_PACKET = 1500;
   localparam int POS_W      = $clog2(MAX_PACKET + 1);
   localparam int LEN_W      = 11;
   localparam int SEQ_W      = 64;
   localparam int CNT_W      = 16;
   localparam int TOTAL_W    = 32;

   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [LEN_W-1:0]   len_type;
   typedef logic [SEQ_W-1:0]   seq_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [TOTAL_W-1:0] total_type;

   // Header layout: sequence number bytes, count bytes, minimum datagram size.
   localparam pos_type SEQ_FIRST = pos_type'(10);
   localparam pos_type CNT_FIRST = pos_type'(18);
   localparam pos_type MIN_LEN   = pos_type'(20);
   localparam pos_type MAX_POS   = pos_type'(MAX_PACKET);

   typedef enum logic [2:0] {
      VERDICT_SHORT     = 3'd0,
      VERDICT_HEARTBEAT = 3'd1,
      VERDICT_DUPLICATE = 3'd2,
      VERDICT_IN_ORDER  = 3'd3,
      VERDICT_GAP       = 3'd4
   } verdict_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      verdict_type verdict;
      len_type     datagram_size;
      seq_type     sequence_number;
      cnt_type     message_count;
      seq_type     missing_count;
      total_type   received_total;
      total_type   duplicate_total;
      total_type   gap_total;
   } rsp_type;

   // Header fields as seen with the current byte included.
   typedef struct packed {
      pos_type len;
      seq_type seq;
      cnt_type cnt;
   } hdr_type;

endpackage

// File: hw/rtl/psgc_stream_if.sv
// Valid/ready channel interfaces for the byte input and the verdict output.
interface psgc_req_if;
   logic              valid;
   logic              ready;
   psgc_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface psgc_rsp_if;
   logic              valid;
   logic              ready;
   psgc_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/packet_sequence_gap_checker.sv
// Top level of the sequenced datagram gap checker.
//
//   channel   direction  content
//   req_if    in         one datagram byte per transfer, with a last-byte mark
//   rsp_if    out        one verdict per datagram, with header fields and totals
//
// One byte is taken every cycle unless a last byte waits for the result register;
// the input register and the result register form a two-stage path, with the
// verdict registered in the result register once that register is free.
// Reset is synchronous and needs no further initialization.
// A stalled result holds only the last byte of the next datagram; other bytes
// keep flowing, since they produce no transfer on the output.
module packet_sequence_gap_checker (
   input logic         clock,
   input logic         reset,
   psgc_req_if.sink    req_if,
   psgc_rsp_if.source  rsp_if
);

   logic              in_valid_ff;
   logic              in_valid_in;
   psgc_pkg::req_type in_data_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   psgc_pkg::rsp_type out_data_ff;

   logic              out_free;
   logic              advance;
   logic              commit;
   logic              accept;
   psgc_pkg::hdr_type hdr;
   psgc_pkg::rsp_type result;

   assign out_free = !out_valid_ff || rsp_if.ready;
   assign advance = in_valid_ff && (!in_data_ff.last_byte || out_free);
   assign commit = advance && in_data_ff.last_byte;
   assign req_if.ready = !in_valid_ff || advance;
   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (commit) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_if.payload;
      end
      if (commit) begin
         out_data_ff <= result;
      end
   end

   psgc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .byte_in (in_data_ff),
      .hdr     (hdr)
   );

   psgc_tracker u_tracker (
      .clock  (clock),
      .reset  (reset),
      .commit (commit),
      .hdr    (hdr),
      .result (result)
   );

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

endmodule

// File: hw/rtl/psgc_parser.sv
// Byte position tracking and header field capture for one datagram.
module psgc_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  psgc_pkg::req_type byte_in,
   output psgc_pkg::hdr_type hdr
);

   psgc_pkg::pos_type pos_ff;
   psgc_pkg::pos_type pos_in;
   psgc_pkg::seq_type seq_ff;
   psgc_pkg::seq_type seq_in;
   psgc_pkg::cnt_type cnt_ff;
   psgc_pkg::cnt_type cnt_in;

   always_comb begin
      seq_in = seq_ff;
      cnt_in = cnt_ff;
      if (pos_ff >= psgc_pkg::SEQ_FIRST && pos_ff < psgc_pkg::CNT_FIRST) begin
         seq_in = {seq_ff[psgc_pkg::SEQ_W-9:0], byte_in.data_byte};
      end else if (pos_ff >= psgc_pkg::CNT_FIRST && pos_ff < psgc_pkg::MIN_LEN) begin
         cnt_in = {cnt_ff[psgc_pkg::CNT_W-9:0], byte_in.data_byte};
      end
      // Length stops counting once the datagram reaches the maximum size.
      if (pos_ff < psgc_pkg::MAX_POS) begin
         pos_in = pos_ff + psgc_pkg::pos_type'(1);
      end else begin
         pos_in = psgc_pkg::MAX_POS;
      end
   end

   assign hdr.len = pos_in;
   assign hdr.seq = seq_in;
   assign hdr.cnt = cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         seq_ff <= '0;
         cnt_ff <= '0;
      end else if (advance) begin
         if (byte_in.last_byte) begin
            pos_ff <= '0;
            seq_ff <= '0;
            cnt_ff <= '0;
         end else begin
            pos_ff <= pos_in;
            seq_ff <= seq_in;
            cnt_ff <= cnt_in;
         end
      end
   end

endmodule

// File: hw/rtl/psgc_tracker.sv
// Sequence tracking, packet classification and running totals.
module psgc_tracker (
   input  logic              clock,
   input  logic              reset,
   input  logic              commit,
   input  psgc_pkg::hdr_type hdr,
   output psgc_pkg::rsp_type result
);

   psgc_pkg::seq_type   expected_ff;
   psgc_pkg::seq_type   expected_in;
   logic                awaiting_ff;
   logic                awaiting_in;
   psgc_pkg::total_type received_ff;
   psgc_pkg::total_type received_in;
   psgc_pkg::total_type duplicate_ff;
   psgc_pkg::total_type duplicate_in;
   psgc_pkg::total_type gap_ff;
   psgc_pkg::total_type gap_in;

   psgc_pkg::seq_type   expected_now;
   psgc_pkg::seq_type   diff;
   logic                borrow;
   logic                is_short;
   logic                is_heartbeat;

   // The first counted packet defines the expected sequence.
   assign expected_now = awaiting_ff ? hdr.seq : expected_ff;
   assign {borrow, diff} = {1'b0, hdr.seq} - {1'b0, expected_now};
   assign is_short = hdr.len < psgc_pkg::MIN_LEN;
   assign is_heartbeat = hdr.cnt == '0;

   always_comb begin
      expected_in = expected_ff;
      awaiting_in = awaiting_ff;
      received_in = received_ff;
      duplicate_in = duplicate_ff;
      gap_in = gap_ff;
      result.verdict = psgc_pkg::VERDICT_SHORT;
      result.datagram_size = psgc_pkg::len_type'(hdr.len);
      result.sequence_number = '0;
      result.message_count = '0;
      result.missing_count = '0;
      if (!is_short) begin
         result.sequence_number = hdr.seq;
         result.message_count = hdr.cnt;
         if (is_heartbeat) begin
            result.verdict = psgc_pkg::VERDICT_HEARTBEAT;
         end else begin
            awaiting_in = 1'b0;
            expected_in = expected_now;
            if (borrow) begin
               result.verdict = psgc_pkg::VERDICT_DUPLICATE;
               duplicate_in = duplicate_ff + psgc_pkg::total_type'(1);
            end else begin
               if (diff != '0) begin
                  result.verdict = psgc_pkg::VERDICT_GAP;
                  result.missing_count = diff;
                  gap_in = gap_ff + psgc_pkg::total_type'(1);
               end else begin
                  result.verdict = psgc_pkg::VERDICT_IN_ORDER;
               end
               expected_in = hdr.seq + psgc_pkg::seq_type'(hdr.cnt);
               received_in = received_ff + psgc_pkg::total_type'(1);
            end
         end
      end
      result.received_total = received_in;
      result.duplicate_total = duplicate_in;
      result.gap_total = gap_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
         awaiting_ff <= 1'b1;
         received_ff <= '0;
         duplicate_ff <= '0;
         gap_ff <= '0;
      end else if (commit) begin
         expected_ff <= expected_in;
         awaiting_ff <= awaiting_in;
         received_ff <= received_in;
         duplicate_ff <= duplicate_in;
         gap_ff <= gap_in;
      end
   end

endmodule

// File: hw/rtl/psgc_checker.sv
// Port-level assertions for the sequence gap checker, bound to its top level.
`include "packet_sequence_gap_checker_defines.svh"

module psgc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input psgc_pkg::rsp_type rsp_payload
);

   // A result that was not taken stays on the port unchanged.
   `PSGC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "rsp changed while stalled")

   // Only a gap verdict carries a nonzero missing count, and a gap always does.
   `PSGC_ASSERT_SAME(a_gap_missing, clock, reset, rsp_valid, (rsp_payload.verdict == psgc_pkg::VERDICT_GAP) == (rsp_payload.missing_count != '0), "missing count disagrees with verdict")

   // A short datagram reports no header fields and a length under the header size.
   `PSGC_ASSERT_SAME(a_short_fields, clock, reset, rsp_valid && rsp_payload.verdict == psgc_pkg::VERDICT_SHORT, rsp_payload.sequence_number == '0 && rsp_payload.message_count == '0 && rsp_payload.datagram_size < psgc_pkg::len_type'(20), "short datagram fields wrong")

   // No result can be pending in the cycle after reset.
   `PSGC_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid, "rsp valid after reset")

endmodule

bind packet_sequence_gap_checker psgc_checker u_psgc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
